@@ rtl/swbrm_pkg.sv @@
// Shared constants, types and helper functions of the bitrate meter.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package swbrm_pkg;

  // Field widths
  localparam int CNT_W  = 32;  // bit count per request
  localparam int TIME_W = 64;  // millisecond timestamp
  localparam int RATE_W = 32;  // reported rates
  localparam int RSSI_W = 16;  // signal strength

  // Ring depth default
  localparam int WINDOW_DEF = 16;

  // Milliseconds per second
  localparam int SCALE = 1000;

  // Request kinds
  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  // Shift-add multiplier: A is consumed one bit per cycle
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 64;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Restoring divider: one quotient bit per cycle, saturating quotient
  localparam int QUO_W = 32;
  localparam int DEN_W = 64;
  localparam int NUM_W = DEN_W + 1 + QUO_W;

  // Write into the ring of slots
  typedef struct packed {
    logic              en;
    logic [CNT_W-1:0]  bits;
    logic [CNT_W-1:0]  step;
  } ring_wr_t;

  // x * 1000 as shifts: 1024 - 16 - 8
  function automatic logic [63:0] times_scale(input logic [63:0] x);
    return (x << 10) - (x << 4) - (x << 3);
  endfunction

  // Clamp a 64-bit value to 32 bits
  function automatic logic [31:0] sat32(input logic [63:0] x);
    return (x[63:32] != 32'd0) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/swbrm_if.sv @@
// Valid/ready channel interfaces for the bitrate meter's requests and results.
// Depends on swbrm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface swbrm_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [swbrm_pkg::CNT_W-1:0]       bit_count;
  logic [swbrm_pkg::TIME_W-1:0]      time_ms;
  logic signed [swbrm_pkg::RSSI_W-1:0] signal_strength;

  modport source (output valid, kind, bit_count, time_ms, signal_strength, input ready);
  modport sink   (input valid, kind, bit_count, time_ms, signal_strength, output ready);
endinterface

interface swbrm_out_if;
  logic                              valid;
  logic                              ready;
  logic [swbrm_pkg::RATE_W-1:0]      window_rate;
  logic [swbrm_pkg::RATE_W-1:0]      average_rate;
  logic signed [swbrm_pkg::RSSI_W-1:0] latest_strength;
  logic                              held;

  modport source (output valid, window_rate, average_rate, latest_strength, held,
                  input ready);
  modport sink   (input valid, window_rate, average_rate, latest_strength, held,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/swbrm_mul.sv @@
// Bit-serial shift-add multiplier: 32 x 64 bits.
// Depends on swbrm_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module swbrm_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [swbrm_pkg::MUL_A_W-1:0] a,
  input  logic [swbrm_pkg::MUL_B_W-1:0] b,
  output logic [swbrm_pkg::PROD_W-1:0]  prod,
  output logic                        busy
);
  import swbrm_pkg::*;

  localparam int CNT_W_L = $clog2(MUL_A_W);

  logic [PROD_W-1:0]  prod_r;
  logic [MUL_B_W-1:0] b_r;
  logic [CNT_W_L-1:0] cnt_r;
  logic               busy_r;
  logic [MUL_B_W-1:0] addend;
  logic [MUL_B_W:0]   sum;

  // LSB of the A part decides whether B is added into the upper half
  assign addend = prod_r[0] ? b_r : '0;
  assign sum    = {1'b0, prod_r[PROD_W-1:MUL_A_W]} + {1'b0, addend};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == CNT_W_L'(MUL_A_W - 1)) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Datapath: shift right one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= {{MUL_B_W{1'b0}}, a};
      b_r    <= b;
    end else if (busy_r) begin
      prod_r <= {sum, prod_r[MUL_A_W-1:1]};
    end
  end

  assign prod = prod_r;
  assign busy = busy_r;

endmodule

`default_nettype wire

@@ rtl/swbrm_div.sv @@
// Bit-serial restoring divider with a quotient clamped to 32 bits.
// A range check first, then one quotient bit per cycle; depends on swbrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swbrm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [swbrm_pkg::NUM_W-1:0] num,
  input  logic [swbrm_pkg::DEN_W-1:0] den,
  output logic [swbrm_pkg::QUO_W-1:0] quo,
  output logic                        busy
);
  import swbrm_pkg::*;

  localparam int CNT_W_L = $clog2(QUO_W);

  logic [DEN_W:0]     rem_r;   // upper numerator part, then partial remainder
  logic [QUO_W-1:0]   low_r;   // numerator bits out, quotient bits in
  logic [DEN_W-1:0]   den_r;
  logic               sat_r;
  logic               chk_r;
  logic               busy_r;
  logic [CNT_W_L-1:0] cnt_r;
  logic [DEN_W:0]     trial;
  logic [DEN_W:0]     diff;
  logic               ge;

  assign trial = {rem_r[DEN_W-1:0], low_r[QUO_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      chk_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      chk_r  <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (chk_r) begin
        chk_r <= 1'b0;
      end else begin
        if (cnt_r == CNT_W_L'(QUO_W - 1)) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NUM_W-1:QUO_W];
      low_r <= num[QUO_W-1:0];
      den_r <= den;
    end else if (busy_r) begin
      if (chk_r) begin
        // quotient overflows 32 bits exactly when the upper part reaches den
        sat_r <= rem_r >= {1'b0, den_r};
      end else begin
        rem_r <= {1'b0, ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0]};
        low_r <= {low_r[QUO_W-2:0], ge};
      end
    end
  end

  assign quo  = sat_r ? '1 : low_r;
  assign busy = busy_r;

endmodule

`default_nettype wire

@@ rtl/swbrm_ring.sv @@
// Ring of (bits, step) slots with running sums over the whole window.
// Reset empties the ring through a fill flag; depends on swbrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swbrm_ring #(
  parameter  int WINDOW = swbrm_pkg::WINDOW_DEF,
  localparam int SUM_W  = swbrm_pkg::CNT_W + $clog2(WINDOW)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  swbrm_pkg::ring_wr_t wr,
  output logic [SUM_W-1:0]    sum_bits,
  output logic [SUM_W-1:0]    sum_steps
);
  import swbrm_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [2*CNT_W-1:0] slot_mem_r [WINDOW];
  logic [2*CNT_W-1:0] rd_r;
  logic [SLOT_W-1:0]  slot_r;
  logic               wrapped_r;
  logic [SUM_W-1:0]   sum_bits_r;
  logic [SUM_W-1:0]   sum_steps_r;
  logic [CNT_W-1:0]   old_bits;
  logic [CNT_W-1:0]   old_step;

  // Slot memory: one write, one registered read at the write pointer
  always_ff @(posedge clk) begin
    rd_r <= slot_mem_r[slot_r];
    if (wr.en) begin
      slot_mem_r[slot_r] <= {wr.bits, wr.step};
    end
  end

  // Slots not yet written since reset read as zero
  assign old_bits = wrapped_r ? rd_r[2*CNT_W-1:CNT_W] : '0;
  assign old_step = wrapped_r ? rd_r[CNT_W-1:0]       : '0;

  // Pointer, fill flag and running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      wrapped_r   <= 1'b0;
      sum_bits_r  <= '0;
      sum_steps_r <= '0;
    end else if (wr.en) begin
      sum_bits_r  <= sum_bits_r  - SUM_W'(old_bits) + SUM_W'(wr.bits);
      sum_steps_r <= sum_steps_r - SUM_W'(old_step) + SUM_W'(wr.step);
      if (slot_r == SLOT_W'(WINDOW - 1)) begin
        slot_r    <= '0;
        wrapped_r <= 1'b1;
      end else begin
        slot_r <= slot_r + 1'b1;
      end
    end
  end

  assign sum_bits  = sum_bits_r;
  assign sum_steps = sum_steps_r;

endmodule

`default_nettype wire

@@ rtl/sliding_window_bitrate_meter.sv @@
// Flow: an update with a nonzero time step passes through the chain divide /
// multiply / divide / divide before its result; start and held requests go
// straight to the output register. A new request is taken only once the last
// result has been handed to the output register.
// Reset (synchronous, rst_n low) clears all measurement state; the ring is
// emptied by its fill flag at once, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_bitrate_meter #(
  parameter int WINDOW = swbrm_pkg::WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  swbrm_in_if.sink         in_ch,
  swbrm_out_if.source      out_ch
);
  import swbrm_pkg::*;

  localparam int SUM_W = CNT_W + $clog2(WINDOW);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;  // start instant-rate divide and average multiply
  localparam logic [2:0] S_INST = 3'd2;  // instant rate ready, start instant * step
  localparam logic [2:0] S_PROD = 3'd3;  // start slot-bits divide and average divide
  localparam logic [2:0] S_SB   = 3'd4;  // write ring, update average
  localparam logic [2:0] S_SUM  = 3'd5;  // start window divide
  localparam logic [2:0] S_WIN  = 3'd6;  // window rate ready
  localparam logic [2:0] S_OUT  = 3'd7;  // hand result to output register

  logic [2:0]        state_r, state_nxt;

  // Measurement state
  logic [CNT_W-1:0]  held_bits_r;
  logic [TIME_W-1:0] prev_r;
  logic [TIME_W-1:0] origin_r;
  logic [RATE_W-1:0] window_r;
  logic [RATE_W-1:0] ra_r;
  logic signed [RSSI_W-1:0] strength_r;
  logic              held_flag_r;

  // Per-update working registers
  logic [CNT_W:0]    s_r;
  logic [TIME_W-1:0] step_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] dprev_r;
  logic [TIME_W-1:0] elapsed_r;
  logic [PROD_W-1:0] ra_prod_r;

  // Output register
  logic              out_valid_r;
  logic [RATE_W-1:0] out_window_r;
  logic [RATE_W-1:0] out_avg_r;
  logic signed [RSSI_W-1:0] out_strength_r;
  logic              out_held_r;

  logic              in_acc;
  logic              out_load;
  logic [TIME_W-1:0] step_in;
  logic              step_zero;
  logic [CNT_W:0]    held_sum;
  logic              elapsed_nz;
  logic              sb_done;
  logic              inst_done;

  // Shared units
  logic              div_a_start, div_b_start, mul_start;
  logic [NUM_W-1:0]  div_a_num, div_b_num;
  logic [DEN_W-1:0]  div_a_den, div_b_den;
  logic [QUO_W-1:0]  div_a_quo, div_b_quo;
  logic              div_a_busy, div_b_busy, mul_busy;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_prod;

  ring_wr_t          ring_wr;
  logic [SUM_W-1:0]  sum_bits;
  logic [SUM_W-1:0]  sum_steps;

  // Handshakes
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // Accept-cycle arithmetic, elapsed check and unit-done flags
  assign step_in    = in_ch.time_ms - prev_r;
  assign step_zero  = (step_in == '0);
  assign held_sum   = {1'b0, held_bits_r} + {1'b0, in_ch.bit_count};
  assign elapsed_nz = (elapsed_r != '0);
  assign inst_done  = !div_a_busy && !mul_busy;
  assign sb_done    = !div_a_busy && !div_b_busy;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) begin
        state_nxt = (in_ch.kind == KIND_UPDATE && !step_zero) ? S_PREP : S_OUT;
      end
      S_PREP: state_nxt = S_INST;
      S_INST: if (inst_done) state_nxt = S_PROD;
      S_PROD: if (!mul_busy) state_nxt = S_SB;
      S_SB:   if (sb_done) state_nxt = S_SUM;
      S_SUM:  state_nxt = S_WIN;
      S_WIN:  if (!div_a_busy) state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Divider A: instant rate, slot bits, window rate
  always_comb begin
    div_a_start = 1'b0;
    div_a_num   = '0;
    div_a_den   = '0;
    unique case (state_r)
      S_PREP: begin
        div_a_start = 1'b1;
        div_a_num   = NUM_W'(times_scale(64'(s_r)));
        div_a_den   = step_r;
      end
      S_PROD: begin
        div_a_start = !mul_busy;
        div_a_num   = NUM_W'(mul_prod);
        div_a_den   = DEN_W'(SCALE);
      end
      S_SUM: begin
        div_a_start = 1'b1;
        div_a_num   = NUM_W'(times_scale(64'(sum_bits)));
        div_a_den   = DEN_W'(sum_steps);
      end
      default: begin
        div_a_start = 1'b0;
      end
    endcase
  end

  // Divider B: time-weighted average
  assign div_b_start = (state_r == S_PROD) && !mul_busy && elapsed_nz;
  assign div_b_num   = NUM_W'(ra_prod_r) + NUM_W'(mul_prod);
  assign div_b_den   = elapsed_r;

  // Multiplier: old average * previous elapsed time, then instant * step
  always_comb begin
    mul_start = 1'b0;
    mul_a     = ra_r;
    mul_b     = dprev_r;
    if (state_r == S_PREP) begin
      mul_start = 1'b1;
    end else if (state_r == S_INST) begin
      mul_start = inst_done;
      mul_a     = div_a_quo;
      mul_b     = step_r;
    end
  end

  // Ring write once the slot bits are known
  assign ring_wr.en   = (state_r == S_SB) && sb_done;
  assign ring_wr.bits = div_a_quo;
  assign ring_wr.step = sat32(step_r);

  // Control and measurement state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_bits_r <= '0;
      prev_r      <= '0;
      origin_r    <= '0;
      window_r    <= '0;
      ra_r        <= '0;
      strength_r  <= '0;
      held_flag_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        held_flag_r <= 1'b0;
        if (in_ch.kind == KIND_START) begin
          origin_r <= in_ch.time_ms;
          prev_r   <= in_ch.time_ms;
          ra_r     <= '0;
        end else begin
          strength_r <= in_ch.signal_strength;
          if (step_zero) begin
            held_bits_r <= held_sum[CNT_W] ? '1 : held_sum[CNT_W-1:0];
            held_flag_r <= 1'b1;
          end else begin
            held_bits_r <= '0;
          end
        end
      end
      if (ring_wr.en) begin
        prev_r <= now_r;
        if (elapsed_nz) begin
          ra_r <= div_b_quo;
        end
      end
      if (state_r == S_WIN && !div_a_busy) begin
        window_r <= div_a_quo;
      end
      // output register
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_r       <= held_sum;
      step_r    <= step_in;
      now_r     <= in_ch.time_ms;
      dprev_r   <= prev_r - origin_r;
      elapsed_r <= in_ch.time_ms - origin_r;
    end
    if (state_r == S_INST && inst_done) begin
      ra_prod_r <= mul_prod;
    end
    if (out_load) begin
      out_window_r   <= window_r;
      out_avg_r      <= ra_r;
      out_strength_r <= strength_r;
      out_held_r     <= held_flag_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.window_rate     = out_window_r;
  assign out_ch.average_rate    = out_avg_r;
  assign out_ch.latest_strength = out_strength_r;
  assign out_ch.held            = out_held_r;

  // Units
  swbrm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .busy  (mul_busy)
  );

  swbrm_div u_div_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_a_start),
    .num   (div_a_num),
    .den   (div_a_den),
    .quo   (div_a_quo),
    .busy  (div_a_busy)
  );

  swbrm_div u_div_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_b_start),
    .num   (div_b_num),
    .den   (div_b_den),
    .quo   (div_b_quo),
    .busy  (div_b_busy)
  );

  swbrm_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (ring_wr),
    .sum_bits  (sum_bits),
    .sum_steps (sum_steps)
  );

  // Checks
  a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("request taken while previous one still in work");

  a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !(div_a_busy || div_b_busy || mul_busy))
    else $error("arithmetic unit busy while sequencer idle");

  a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
    ring_wr.en |-> (ring_wr.step != '0))
    else $error("zero time step written into ring");

  a_held_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ring_wr.en |-> (held_bits_r == '0))
    else $error("held bits not consumed by ring write");

endmodule

`default_nettype wire

@@ sim/swbrm_checker.sv @@
// Checker for the bitrate meter: watches both channels, predicts each result
// and compares it with what the block returns. Depends on swbrm_pkg and swbrm_if.
`timescale 1ns / 1ps

module swbrm_checker #(
  parameter int WINDOW = swbrm_pkg::WINDOW_DEF
) (
  input  logic clk,
  input  logic rst_n,
  swbrm_in_if  in_mon,
  swbrm_out_if out_mon,
  output int   fail_count,
  output int   pending
);
  import swbrm_pkg::*;

  localparam logic [63:0] RATE_MAX = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [RATE_W-1:0]        window_rate;
    logic [RATE_W-1:0]        average_rate;
    logic signed [RSSI_W-1:0] latest_strength;
    logic                     held;
  } meter_result_t;

  meter_result_t expected_q[$];

  // Predicted measurement state
  logic [CNT_W-1:0]         ring_bits [WINDOW];
  logic [CNT_W-1:0]         ring_step [WINDOW];
  int unsigned              wr_slot;
  logic [CNT_W-1:0]         carry_bits;
  logic [TIME_W-1:0]        last_ms;
  logic [TIME_W-1:0]        origin_ms;
  logic [RATE_W-1:0]        win_rate;
  logic [RATE_W-1:0]        avg_rate;
  logic signed [RSSI_W-1:0] strength;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [31:0] limit32(input logic [63:0] x);
    return (x > RATE_MAX) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  // Advance the predicted state by one request and return the result it gives
  function automatic meter_result_t predict_meter(input logic kind,
                                                  input logic [31:0] bits,
                                                  input logic [63:0] now,
                                                  input logic signed [15:0] rssi);
    logic [63:0]   step;
    logic [63:0]   total;
    logic [63:0]   inst;
    logic [63:0]   weighted;
    logic [63:0]   sum_bits;
    logic [63:0]   sum_steps;
    logic [63:0]   span;
    logic [63:0]   elapsed;
    logic [127:0]  num;
    logic [127:0]  quo;
    meter_result_t r;
    r.held = 1'b0;
    if (kind == KIND_START) begin
      origin_ms = now;
      last_ms   = now;
      avg_rate  = '0;
    end else begin
      step     = now - last_ms;
      strength = rssi;
      total    = 64'(carry_bits) + 64'(bits);
      if (step == 64'd0) begin
        // no time passed: bits wait for the next nonzero step
        carry_bits = limit32(total);
        r.held     = 1'b1;
      end else begin
        carry_bits = '0;
        inst = total * 64'd1000 / step;
        if (inst > RATE_MAX) inst = RATE_MAX;
        weighted = inst * step;
        ring_bits[wr_slot] = limit32(weighted / 64'd1000);
        ring_step[wr_slot] = limit32(step);
        wr_slot = (wr_slot == WINDOW - 1) ? 0 : wr_slot + 1;
        sum_bits  = '0;
        sum_steps = '0;
        for (int i = 0; i < WINDOW; i++) begin
          sum_bits  += 64'(ring_bits[i]);
          sum_steps += 64'(ring_step[i]);
        end
        win_rate = limit32(sum_bits * 64'd1000 / sum_steps);
        // time-weighted average; kept as is when no time has elapsed
        elapsed = now - origin_ms;
        span    = last_ms - origin_ms;
        if (elapsed != 64'd0) begin
          num = 128'(avg_rate) * 128'(span) + 128'(weighted);
          quo = num / 128'(elapsed);
          avg_rate = (quo > 128'(RATE_MAX)) ? 32'hFFFF_FFFF : quo[31:0];
        end
        last_ms = now;
      end
    end
    r.window_rate     = win_rate;
    r.average_rate    = avg_rate;
    r.latest_strength = strength;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint want, input longint got);
    fail_count++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin : monitor
    meter_result_t got;
    meter_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring_bits[i] = '0;
        ring_step[i] = '0;
      end
      wr_slot    = 0;
      carry_bits = '0;
      last_ms    = '0;
      origin_ms  = '0;
      win_rate   = '0;
      avg_rate   = '0;
      strength   = '0;
      expected_q.delete();
    end else begin
      // accepted request
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(predict_meter(in_mon.kind, in_mon.bit_count, in_mon.time_ms,
                                           in_mon.signal_strength));
      // accepted result
      if (out_mon.valid && out_mon.ready) begin
        got.window_rate     = out_mon.window_rate;
        got.average_rate    = out_mon.average_rate;
        got.latest_strength = out_mon.latest_strength;
        got.held            = out_mon.held;
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with no request pending: expected none, actual %p",
                   $time, got);
        end else begin
          want = expected_q.pop_front();
          if (got.window_rate !== want.window_rate)
            report_mismatch("window_rate", want.window_rate, got.window_rate);
          if (got.average_rate !== want.average_rate)
            report_mismatch("average_rate", want.average_rate, got.average_rate);
          if (got.latest_strength !== want.latest_strength)
            report_mismatch("latest_strength", $signed(want.latest_strength),
                            $signed(got.latest_strength));
          if (got.held !== want.held)
            report_mismatch("held", want.held, got.held);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ sim/testbench.sv @@
// Top of the bitrate meter testbench: clock, reset, request stimulus, result
// back-pressure and verdict. Depends on swbrm_pkg, swbrm_if, the block and swbrm_checker.
`timescale 1ns / 1ps

module testbench;
  import swbrm_pkg::*;

  localparam int RESET_CYCLES    = 11;
  localparam int LIMIT_CYCLES    = 1_000_000;
  localparam int DRAIN_CYCLES    = 160;
  localparam int HOLD_CYCLES     = 800;
  localparam int BURST_REQUESTS  = 60;
  localparam int RANDOM_REQUESTS = 1040;
  localparam int QUIET_REQUESTS  = 150;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;

  logic [63:0] now_ms;
  bit          long_hold_pending = 1'b0;
  bit          no_idle = 1'b0;

  swbrm_in_if  in_ch();
  swbrm_out_if out_ch();

  sliding_window_bitrate_meter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  swbrm_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result back-pressure: random stalls, one long hold-off, none at the end
  initial begin : result_stall
    int   run_len;
    logic level;
    forever begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        level   = 1'b0;
        run_len = HOLD_CYCLES;
      end else if (no_idle) begin
        level   = 1'b1;
        run_len = 1;
      end else if ($urandom_range(0, 2) == 0) begin
        level   = 1'b0;
        run_len = $urandom_range(1, 14);
      end else begin
        level   = 1'b1;
        run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 40);
      end
      out_ch.ready <= level;
      repeat (run_len) @(posedge clk);
    end
  end

  function automatic logic [31:0] pick_bits();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 100000);
      4, 5, 6, 7: return $urandom_range(0, 1 << 20);
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_step();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 64'($urandom_range(1, 50));
      6, 7, 8:          return 64'($urandom_range(1, 5000));
      default:          return {30'd0, 2'($urandom_range(0, 3)), 32'($urandom)};
    endcase
  endfunction

  // Offer one request, sometimes after a random gap, and wait until it is taken
  task automatic send_request(input logic kind, input logic [31:0] bits,
                              input logic [63:0] stamp, input logic signed [15:0] rssi);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.kind            <= kind;
    in_ch.bit_count       <= bits;
    in_ch.time_ms         <= stamp;
    in_ch.signal_strength <= rssi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop offering until every pending result has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly updates with rising time; some starts, repeated stamps and jumps
  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      case ($urandom_range(0, 2))
        0:       now_ms = {$urandom, $urandom};
        1:       now_ms = 64'($urandom_range(0, 100000));
        default: ;
      endcase
      send_request(KIND_START, $urandom, now_ms, 16'($urandom));
    end else if (pick < 14) begin
      send_request(KIND_UPDATE, pick_bits(), now_ms, 16'($urandom));
    end else if (pick < 18) begin
      now_ms = pick[0] ? {$urandom, $urandom} : now_ms - 64'($urandom_range(1, 5000));
      send_request(KIND_UPDATE, pick_bits(), now_ms, 16'($urandom));
    end else begin
      now_ms = now_ms + pick_step();
      send_request(KIND_UPDATE, pick_bits(), now_ms, 16'($urandom));
    end
  endtask

  initial begin : stimulus
    in_ch.valid           <= 1'b0;
    in_ch.kind            <= KIND_START;
    in_ch.bit_count       <= '0;
    in_ch.time_ms         <= '0;
    in_ch.signal_strength <= '0;
    rst_n                 <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero step right after reset, held bits saturate
    send_request(KIND_UPDATE, 32'hFFFF_FFFF, 64'd0, 16'sh8000);
    send_request(KIND_UPDATE, 32'd5, 64'd0, 16'sh7FFF);
    // start ignores bits and strength
    send_request(KIND_START, 32'd77, 64'd1000, 16'sd123);
    send_request(KIND_UPDATE, 32'd0, 64'd1000, 16'sd0);
    // instant rate saturates, then a step beyond 32 bits
    send_request(KIND_UPDATE, 32'hFFFF_FFFF, 64'd1001, -16'sd1);
    send_request(KIND_UPDATE, 32'd12345, 64'd1001 + 64'h1_0000_0005, 16'sd40);
    send_request(KIND_UPDATE, 32'd0, 64'd1016 + 64'h1_0000_0000, -16'sd90);
    // stamps at the top of the range and wrapping past it
    send_request(KIND_START, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0, 16'sh7FFF);
    send_request(KIND_UPDATE, 32'd1000, 64'hFFFF_FFFF_FFFF_FFFF, 16'sd7);
    send_request(KIND_UPDATE, 32'd1000, 64'd5, 16'sd8);
    // time going backwards
    send_request(KIND_UPDATE, 32'd300, 64'd2, 16'sd9);
    // nonzero step with no time elapsed since the start keeps the average
    send_request(KIND_START, 32'd0, 64'd500, 16'sd0);
    send_request(KIND_UPDATE, 32'd4000, 64'd600, 16'sd10);
    send_request(KIND_UPDATE, 32'd4000, 64'd500, 16'sd11);
    send_request(KIND_UPDATE, 32'd1, 64'd501, 16'sh8000);
    now_ms = 64'd501;
    settle();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 300) begin
        // long hold-off on results while fast requests keep coming
        long_hold_pending = 1'b1;
        repeat (BURST_REQUESTS) send_request(KIND_UPDATE, pick_bits(), now_ms, 16'($urandom));
      end
      if (n == 600) settle();
      if (n == RANDOM_REQUESTS - QUIET_REQUESTS) no_idle = 1'b1;
      random_request();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
